// ===== src/dllm_pkg.sv =====
package dllm_pkg;
	localparam int CAPACITY = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int ADR_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(CAPACITY);

	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_INS_TAIL = 3'd1;
	localparam logic [2:0] CMD_INS_POS  = 3'd2;
	localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
	localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
	localparam logic [2:0] CMD_DEL_POS  = 3'd5;
	localparam logic [2:0] CMD_SHOW_FWD = 3'd6;
	localparam logic [2:0] CMD_SHOW_REV = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// sequencer commands to the link datapath
	typedef struct packed {
		logic                   wr_en;
		logic [ADR_W-1:0]       wr_adr;
		logic [VALUE_WIDTH-1:0] wr_val;
		logic [IDX_W-1:0]       wr_nxt;
		logic [IDX_W-1:0]       wr_prv;
		logic                   rd_en;
		logic [ADR_W-1:0]       rd_adr;
	} node_ctl_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] val;
		logic [IDX_W-1:0]       nxt;
		logic [IDX_W-1:0]       prv;
	} node_t;
endpackage

// ===== src/dllm_ram.sv =====
module dllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_adr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_adr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_adr] <= wr_data;
		if (rd_en) rd_data <= mem_q[rd_adr];
	end
endmodule

// ===== src/dllm_node_store.sv =====
module dllm_node_store (
	input  logic              clk,
	input  dllm_pkg::node_ctl_t ctl,
	output dllm_pkg::node_t   rd_node
);
	localparam int NW = dllm_pkg::VALUE_WIDTH + 2 * dllm_pkg::IDX_W;
	logic [NW-1:0] rd_raw;

	dllm_ram #(.WIDTH(NW), .DEPTH(dllm_pkg::CAPACITY)) u_ram (
		.clk(clk),
		.wr_en(ctl.wr_en),
		.wr_adr(ctl.wr_adr),
		.wr_data({ctl.wr_val, ctl.wr_nxt, ctl.wr_prv}),
		.rd_en(ctl.rd_en),
		.rd_adr(ctl.rd_adr),
		.rd_data(rd_raw)
	);

	assign rd_node = dllm_pkg::node_t'(rd_raw);
endmodule

// ===== src/doubly_linked_list_manager_unit.sv =====
// an error or an empty show goes from decode straight to the result state
// positional commands walk the links from the head, one read per link walked
// show: each element is read from the store, then sent from the show state
// throughput: one command at a time, the input stalls until the sequencer is idle again
// results leave through an output register; the sequencer waits while it is held
// reset: asynchronous, empties the list (used mask, head, tail, count cleared)
module doubly_linked_list_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic signed [31:0] value,
	input  logic [5:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] element,
	output logic        last,
	output logic [5:0]  length
);
	localparam int IW = dllm_pkg::IDX_W;
	localparam int AW = dllm_pkg::ADR_W;
	localparam int VW = dllm_pkg::VALUE_WIDTH;
	localparam int CW = $clog2(dllm_pkg::CAPACITY + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;  // issue read of cur
	localparam logic [3:0] S_WAIT  = 4'd3;  // read data arrives
	localparam logic [3:0] S_INS   = 4'd4;  // cur node read, insert before it
	localparam logic [3:0] S_FIX   = 4'd5;  // patch neighbor pointer
	localparam logic [3:0] S_FIX2  = 4'd6;
	localparam logic [3:0] S_DEL   = 4'd7;  // cur node read, unlink it
	localparam logic [3:0] S_SHOW  = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;
	localparam logic [3:0] S_NBR   = 4'd10; // neighbor read for link patch
	localparam logic [3:0] S_NBR2  = 4'd11;

	logic [3:0]  state_q;
	logic [2:0]  cmd_q;
	logic [VW-1:0] val_q;
	logic [5:0]  pos_q;
	logic [dllm_pkg::CAPACITY-1:0] used_q;
	logic [IW-1:0] head_q, tail_q, cur_q, newn_q, pv_q, nx_q;
	logic [CW-1:0] count_q;
	logic [5:0]  steps_q;
	logic        ins_q;
	logic [1:0]  fix_q;     // which neighbor patches remain
	logic [IW-1:0] fix_adr_q;
	logic        fix_is_prev_q; // patch prv field else nxt field
	logic [IW-1:0] fix_val_q;

	dllm_pkg::node_ctl_t ctl;
	dllm_pkg::node_t     rd_node;

	dllm_node_store u_store (.clk(clk), .ctl(ctl), .rd_node(rd_node));

	// output register
	logic        ov_q;
	logic [1:0]  ost_q;
	logic [31:0] oel_q;
	logic        olast_q;
	logic [5:0]  olen_q;

	assign out_valid = ov_q;
	assign status    = ost_q;
	assign element   = oel_q;
	assign last      = olast_q;
	assign length    = olen_q;
	assign in_stall  = (state_q != S_IDLE);

	wire out_free = !ov_q || !out_stall;

	// lowest free slot, priority search over the used mask
	logic [IW-1:0] free_idx;
	always_comb begin
		free_idx = dllm_pkg::NIL_IDX;
		for (int i = dllm_pkg::CAPACITY - 1; i >= 0; i--)
			if (!used_q[i]) free_idx = IW'(i);
	end

	wire [31:0] shown = 32'(signed'(rd_node.val));

	// positional insert one past the end behaves as a tail insert
	wire append_tail = (cmd_q == dllm_pkg::CMD_INS_POS) && !ins_q &&
		(7'(pos_q) == 7'(count_q) + 7'd1);
	wire tail_side = (cmd_q == dllm_pkg::CMD_INS_TAIL) || !ins_q;
	wire pool_full = (count_q >= CW'(dllm_pkg::CAPACITY));

	// result to send
	logic        snd;
	logic [1:0]  snd_st;
	logic [31:0] snd_el;
	logic        snd_last;
	logic [1:0]  rst_q;

	always_comb begin
		ctl = '0;
		ctl.wr_val = val_q;
		snd = 1'b0;
		snd_st = rst_q;
		snd_el = '0;
		snd_last = 1'b1;
		unique case (state_q)
			S_WALK: begin
				ctl.rd_en = 1'b1;
				ctl.rd_adr = AW'(cur_q);
			end
			S_INS: begin
				// new node takes cur's place, before cur
				ctl.wr_en = 1'b1;
				ctl.wr_adr = AW'(newn_q);
				ctl.wr_nxt = cur_q;
				ctl.wr_prv = rd_node.prv;
			end
			S_NBR: begin
				ctl.rd_en = 1'b1;
				ctl.rd_adr = AW'(fix_adr_q);
			end
			S_FIX: begin
				ctl.wr_en = 1'b1;
				ctl.wr_adr = AW'(fix_adr_q);
				ctl.wr_val = rd_node.val;
				ctl.wr_nxt = fix_is_prev_q ? rd_node.nxt : fix_val_q;
				ctl.wr_prv = fix_is_prev_q ? fix_val_q : rd_node.prv;
			end
			S_SHOW: begin
				snd = 1'b1;
				snd_st = dllm_pkg::ST_OK;
				snd_el = shown;
				snd_last = (steps_q == 6'd1);
			end
			S_RES: snd = 1'b1;
			default: ;
		endcase
		if (state_q == S_DEC && (ins_q || append_tail) && !pool_full) begin
			// head/tail insert writes the new node at once, only when a slot is free
			ctl.wr_en = 1'b1;
			ctl.wr_adr = AW'(free_idx);
			ctl.wr_nxt = tail_side ? dllm_pkg::NIL_IDX : head_q;
			ctl.wr_prv = tail_side ? tail_q : dllm_pkg::NIL_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			head_q <= dllm_pkg::NIL_IDX;
			tail_q <= dllm_pkg::NIL_IDX;
			count_q <= '0;
			ov_q <= 1'b0;
			ins_q <= 1'b0;
			fix_q <= '0;
		end else begin
			if (ov_q && !out_stall && !(snd && out_free)) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						val_q <= VW'(value);
						pos_q <= position;
						state_q <= S_DEC;
						ins_q <= (command == dllm_pkg::CMD_INS_HEAD ||
							command == dllm_pkg::CMD_INS_TAIL ||
							(command == dllm_pkg::CMD_INS_POS && position == 6'd1));
					end
				end
				S_DEC: begin
					if (cmd_q <= dllm_pkg::CMD_INS_POS) begin
						if (cmd_q == dllm_pkg::CMD_INS_POS &&
							(pos_q == 0 || 7'(pos_q) > 7'(count_q) + 7'd1)) begin
							rst_q <= dllm_pkg::ST_BADPOS;
							state_q <= S_RES;
						end else if (pool_full) begin
							rst_q <= dllm_pkg::ST_FULL;
							state_q <= S_RES;
						end else begin
							rst_q <= dllm_pkg::ST_OK;
							used_q[AW'(free_idx)] <= 1'b1;
							newn_q <= free_idx;
							count_q <= count_q + 1'b1;
							if (ins_q) begin
								if (head_q == dllm_pkg::NIL_IDX) begin
									head_q <= free_idx;
									tail_q <= free_idx;
									state_q <= S_RES;
								end else begin
									if (cmd_q == dllm_pkg::CMD_INS_TAIL) tail_q <= free_idx;
									else head_q <= free_idx;
									fix_q <= 2'd1;
									fix_adr_q <= (cmd_q == dllm_pkg::CMD_INS_TAIL) ? tail_q : head_q;
									fix_is_prev_q <= (cmd_q != dllm_pkg::CMD_INS_TAIL);
									fix_val_q <= free_idx;
									state_q <= S_NBR;
								end
							end else if (append_tail) begin
								// append at tail, then patch old tail
								ins_q <= 1'b1;
								tail_q <= free_idx;
								fix_q <= 2'd1;
								fix_adr_q <= tail_q;
								fix_is_prev_q <= 1'b0;
								fix_val_q <= free_idx;
								state_q <= S_NBR;
								cmd_q <= dllm_pkg::CMD_INS_TAIL;
							end else begin
								cur_q <= head_q;
								steps_q <= pos_q - 6'd1;
								state_q <= S_WALK;
							end
						end
					end else if (cmd_q <= dllm_pkg::CMD_DEL_POS) begin
						if (cmd_q == dllm_pkg::CMD_DEL_POS && pos_q == 0) begin
							rst_q <= dllm_pkg::ST_BADPOS;
							state_q <= S_RES;
						end else if (count_q == 0) begin
							rst_q <= (cmd_q == dllm_pkg::CMD_DEL_POS && pos_q != 6'd1) ?
								dllm_pkg::ST_BADPOS : dllm_pkg::ST_EMPTY;
							state_q <= S_RES;
						end else if (cmd_q == dllm_pkg::CMD_DEL_POS && 7'(pos_q) > 7'(count_q)) begin
							rst_q <= dllm_pkg::ST_BADPOS;
							state_q <= S_RES;
						end else begin
							rst_q <= dllm_pkg::ST_OK;
							cur_q <= (cmd_q == dllm_pkg::CMD_DEL_TAIL) ? tail_q : head_q;
							steps_q <= (cmd_q == dllm_pkg::CMD_DEL_POS) ? pos_q - 6'd1 : 6'd0;
							state_q <= S_WALK;
						end
					end else begin
						if (count_q == 0) begin
							rst_q <= dllm_pkg::ST_EMPTY;
							state_q <= S_RES;
						end else begin
							rst_q <= dllm_pkg::ST_OK;
							steps_q <= 6'(count_q);
							cur_q <= (cmd_q == dllm_pkg::CMD_SHOW_FWD) ? head_q : tail_q;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: state_q <= S_WAIT;
				S_WAIT: begin
					if (cmd_q >= dllm_pkg::CMD_SHOW_FWD) state_q <= S_SHOW;
					else if (steps_q != 0) begin
						cur_q <= rd_node.nxt;
						steps_q <= steps_q - 6'd1;
						state_q <= S_WALK;
					end else if (cmd_q == dllm_pkg::CMD_INS_POS) state_q <= S_INS;
					else state_q <= S_DEL;
				end
				S_INS: begin
					// cur.prv = new, prev.nxt = new (prev exists since pos > 1)
					fix_q <= 2'd2;
					fix_adr_q <= cur_q;
					fix_is_prev_q <= 1'b1;
					fix_val_q <= newn_q;
					pv_q <= rd_node.prv;
					state_q <= S_NBR;
				end
				S_DEL: begin
					used_q[AW'(cur_q)] <= 1'b0;
					count_q <= count_q - 1'b1;
					pv_q <= rd_node.prv;
					nx_q <= rd_node.nxt;
					if (rd_node.prv == dllm_pkg::NIL_IDX) head_q <= rd_node.nxt;
					if (rd_node.nxt == dllm_pkg::NIL_IDX) tail_q <= rd_node.prv;
					if (rd_node.prv != dllm_pkg::NIL_IDX) begin
						fix_adr_q <= rd_node.prv;
						fix_is_prev_q <= 1'b0;
						fix_val_q <= rd_node.nxt;
						fix_q <= (rd_node.nxt != dllm_pkg::NIL_IDX) ? 2'd3 : 2'd1;
						state_q <= S_NBR;
					end else if (rd_node.nxt != dllm_pkg::NIL_IDX) begin
						fix_adr_q <= rd_node.nxt;
						fix_is_prev_q <= 1'b1;
						fix_val_q <= rd_node.prv;
						fix_q <= 2'd1;
						state_q <= S_NBR;
					end else state_q <= S_RES;
				end
				S_NBR: state_q <= S_NBR2;
				S_NBR2: state_q <= S_FIX;
				S_FIX: begin
					if (fix_q == 2'd2) begin
						// second patch of a positional insert
						fix_adr_q <= pv_q;
						fix_is_prev_q <= 1'b0;
						fix_val_q <= newn_q;
						fix_q <= 2'd1;
						state_q <= S_NBR;
					end else if (fix_q == 2'd3) begin
						fix_adr_q <= nx_q;
						fix_is_prev_q <= 1'b1;
						fix_val_q <= pv_q;
						fix_q <= 2'd1;
						state_q <= S_NBR;
					end else state_q <= S_RES;
				end
				S_SHOW: begin
					if (out_free) begin
						ov_q <= 1'b1;
						ost_q <= snd_st;
						oel_q <= snd_el;
						olast_q <= snd_last;
						olen_q <= 6'(count_q);
						if (steps_q == 6'd1) state_q <= S_IDLE;
						else begin
							steps_q <= steps_q - 6'd1;
							cur_q <= (cmd_q == dllm_pkg::CMD_SHOW_FWD) ? rd_node.nxt : rd_node.prv;
							state_q <= S_WALK;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						ov_q <= 1'b1;
						ost_q <= snd_st;
						oel_q <= snd_el;
						olast_q <= snd_last;
						olen_q <= 6'(count_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/dllm_checker.sv =====
module dllm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [31:0] element,
	input logic       last,
	input logic [5:0] length
);
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= 6'(dllm_pkg::CAPACITY)) else $error("length above capacity");
	a_el: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dllm_pkg::ST_OK |-> element == 32'd0)
		else $error("element on error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(last))
		else $error("stalled result changed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("took two commands");
endmodule

bind doubly_linked_list_manager_unit dllm_checker u_chk (.*);
